// ===== sv/hcc_pkg.sv =====
// Shared types, constants and helpers for the hysteresis climate controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package hcc_pkg;

    localparam int TEMP_W  = 11;
    localparam int HUM_W   = 10;
    localparam int BAND_TW = 7;
    localparam int BAND_HW = 8;
    localparam int RATE_W  = 14;
    localparam int CNT_W   = 16;
    localparam int EST_W   = 18;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int IN_DW   = 24;
    localparam int OUT_DW  = 24;

    localparam logic [CNT_W-1:0]       CNT_MAX = {CNT_W{1'b1}};
    localparam logic signed [EST_W:0]  EST_MIN = -19'sd40000;
    localparam logic signed [EST_W:0]  EST_MAX = 19'sd80000;
    localparam logic signed [EST_W:0]  SCALE   = 19'sd100;

    localparam logic signed [TEMP_W-1:0] TEMP_TARGET_RST = 11'sd375;
    localparam logic [BAND_TW-1:0]       TEMP_BAND_RST   = 7'd2;
    localparam logic [HUM_W-1:0]         HUM_TARGET_RST  = 10'd550;
    localparam logic [BAND_HW-1:0]       HUM_BAND_RST    = 8'd30;
    localparam logic [RATE_W-1:0]        GAIN_RATE_RST   = 14'd20;
    localparam logic [RATE_W-1:0]        LOSS_RATE_RST   = 14'd10;
    localparam logic [CNT_W-1:0]         TIMEOUT_RST     = 16'd120;
    localparam logic [CNT_W-1:0]         PAUSE_LIM_RST   = 16'd300;

    typedef enum logic [IDX_W-1:0] {
        REG_TEMP_TARGET    = 3'd0,
        REG_TEMP_BAND      = 3'd1,
        REG_HUM_TARGET     = 3'd2,
        REG_HUM_BAND       = 3'd3,
        REG_HEAT_GAIN_RATE = 3'd4,
        REG_HEAT_LOSS_RATE = 3'd5,
        REG_SENSOR_TIMEOUT = 3'd6,
        REG_PAUSE_LIMIT    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_target;
        logic [BAND_TW-1:0]       temp_band;
        logic [HUM_W-1:0]         hum_target;
        logic [BAND_HW-1:0]       hum_band;
        logic [RATE_W-1:0]        heat_gain_rate;
        logic [RATE_W-1:0]        heat_loss_rate;
        logic [CNT_W-1:0]         sensor_timeout_ticks;
        logic [CNT_W-1:0]         pause_limit_ticks;
    } cfg_t;

    typedef struct packed {
        logic                     reading_valid;
        logic signed [TEMP_W-1:0] temp_sample;
        logic [HUM_W-1:0]         hum_sample;
        logic                     pause_press;
    } tick_t;

    typedef struct packed {
        logic                     heater_state;
        logic                     humid_state;
        logic                     paused;
        logic [CNT_W-1:0]         pause_age;
        logic [CNT_W-1:0]         ticks_since_reading;
        logic                     have_reading;
        logic signed [TEMP_W-1:0] last_temp;
        logic [HUM_W-1:0]         last_hum;
        logic signed [EST_W-1:0]  estimate;
    } ctl_state_t;

    typedef struct packed {
        logic                    heater_on;
        logic                    humidifier_on;
        logic                    pause_active;
        logic                    sensor_ok;
        logic signed [EST_W-1:0] temp_estimate;
    } result_t;

    function automatic logic signed [EST_W-1:0] clamp_est(input logic signed [EST_W:0] v);
        logic signed [EST_W:0] r;
        begin
            r = v;
            if (v < EST_MIN)
            begin
                r = EST_MIN;
            end
            else if (v > EST_MAX)
            begin
                r = EST_MAX;
            end
            return r[EST_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/hcc_cfg_regs.sv =====
// Configuration register file of the climate controller.
// Depends on hcc_pkg for the register layout and reset values.
`default_nettype none

module hcc_cfg_regs
    import hcc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_target          <= TEMP_TARGET_RST;
            cfg_reg.temp_band            <= TEMP_BAND_RST;
            cfg_reg.hum_target           <= HUM_TARGET_RST;
            cfg_reg.hum_band             <= HUM_BAND_RST;
            cfg_reg.heat_gain_rate       <= GAIN_RATE_RST;
            cfg_reg.heat_loss_rate       <= LOSS_RATE_RST;
            cfg_reg.sensor_timeout_ticks <= TIMEOUT_RST;
            cfg_reg.pause_limit_ticks    <= PAUSE_LIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TEMP_TARGET:    cfg_reg.temp_target <= $signed(cfg_data[TEMP_W-1:0]);
                REG_TEMP_BAND:      cfg_reg.temp_band <= cfg_data[BAND_TW-1:0];
                REG_HUM_TARGET:     cfg_reg.hum_target <= cfg_data[HUM_W-1:0];
                REG_HUM_BAND:       cfg_reg.hum_band <= cfg_data[BAND_HW-1:0];
                REG_HEAT_GAIN_RATE: cfg_reg.heat_gain_rate <= cfg_data[RATE_W-1:0];
                REG_HEAT_LOSS_RATE: cfg_reg.heat_loss_rate <= cfg_data[RATE_W-1:0];
                REG_SENSOR_TIMEOUT: cfg_reg.sensor_timeout_ticks <= cfg_data[CNT_W-1:0];
                REG_PAUSE_LIMIT:    cfg_reg.pause_limit_ticks <= cfg_data[CNT_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/hcc_step.sv =====
// One-tick control step: pause timer, sensor timeout, hysteresis decisions
// and the saturating temperature estimate. Depends on hcc_pkg.
`default_nettype none

module hcc_step
    import hcc_pkg::*;
(
    input  wire cfg_t       cfg,
    input  wire tick_t      tick,
    input  wire ctl_state_t state,
    output ctl_state_t      state_next,
    output result_t         result
);

    logic                    p0;
    logic                    p1;
    logic [CNT_W-1:0]        age1;
    logic                    ok;
    logic signed [12:0]      tgt_hi;
    logic signed [12:0]      tgt_lo;
    logic signed [12:0]      temp_x;
    logic signed [EST_W:0]   temp_scaled;
    logic signed [EST_W:0]   hi_scaled;
    logic signed [EST_W:0]   lo_scaled;
    logic signed [EST_W:0]   est_up;
    logic signed [EST_W:0]   est_dn;
    logic signed [EST_W-1:0] est_new;
    logic signed [11:0]      hum_x;
    logic signed [11:0]      hum_hi;
    logic signed [11:0]      hum_lo;
    ctl_state_t              s;

    always_comb
    begin
        s = state;

        // pause expiry, toggle, then age
        p0 = state.paused;
        if (state.paused && (state.pause_age >= cfg.pause_limit_ticks))
        begin
            p0 = 1'b0;
        end
        p1   = p0;
        age1 = state.pause_age;
        if (tick.pause_press)
        begin
            p1 = !p0;
            if (!p0)
            begin
                age1 = '0;
            end
        end
        if (p1 && (age1 != CNT_MAX))
        begin
            age1 = age1 + 1'b1;
        end
        s.paused    = p1;
        s.pause_age = age1;

        // sensor bookkeeping
        if (tick.reading_valid)
        begin
            s.last_temp           = tick.temp_sample;
            s.last_hum            = tick.hum_sample;
            s.ticks_since_reading = '0;
            s.have_reading        = 1'b1;
        end
        else if (state.ticks_since_reading != CNT_MAX)
        begin
            s.ticks_since_reading = state.ticks_since_reading + 1'b1;
        end

        ok = s.have_reading && (s.ticks_since_reading < cfg.sensor_timeout_ticks);

        tgt_hi = 13'(cfg.temp_target) + $signed({6'd0, cfg.temp_band});
        tgt_lo = 13'(cfg.temp_target) - $signed({6'd0, cfg.temp_band});
        temp_x = 13'(s.last_temp);
        temp_scaled = (EST_W+1)'(s.last_temp) * SCALE;
        hi_scaled   = (EST_W+1)'(tgt_hi) * SCALE;
        lo_scaled   = (EST_W+1)'(tgt_lo) * SCALE;
        est_up = (EST_W+1)'(state.estimate) + $signed({5'd0, cfg.heat_gain_rate});
        est_dn = (EST_W+1)'(state.estimate) - $signed({5'd0, cfg.heat_loss_rate});

        hum_x  = $signed({2'd0, s.last_hum});
        hum_hi = $signed({2'd0, cfg.hum_target}) + $signed({4'd0, cfg.hum_band});
        hum_lo = $signed({2'd0, cfg.hum_target}) - $signed({4'd0, cfg.hum_band});

        est_new = state.estimate;
        if (s.have_reading)
        begin
            if (ok)
            begin
                est_new = clamp_est(temp_scaled);
                if (state.heater_state)
                begin
                    if (temp_x >= tgt_hi)
                    begin
                        s.heater_state = 1'b0;
                    end
                end
                else if (temp_x < tgt_lo)
                begin
                    s.heater_state = 1'b1;
                end
                if (!p1)
                begin
                    if (state.humid_state)
                    begin
                        if (hum_x >= hum_hi)
                        begin
                            s.humid_state = 1'b0;
                        end
                    end
                    else if (hum_x < hum_lo)
                    begin
                        s.humid_state = 1'b1;
                    end
                end
            end
            else if (state.heater_state)
            begin
                est_new = clamp_est(est_up);
                if ((EST_W+1)'(est_new) >= hi_scaled)
                begin
                    s.heater_state = 1'b0;
                end
            end
            else
            begin
                est_new = clamp_est(est_dn);
                if ((EST_W+1)'(est_new) < lo_scaled)
                begin
                    s.heater_state = 1'b1;
                end
            end
        end
        s.estimate = est_new;

        state_next           = s;
        result.heater_on     = s.heater_state;
        result.humidifier_on = s.humid_state && !p1;
        result.pause_active  = p1;
        result.sensor_ok     = ok;
        result.temp_estimate = est_new;
    end

endmodule

`default_nettype wire

// ===== sv/hysteresis_climate_controller_core.sv =====
// Top level of the hysteresis climate controller: input register, control
// state, result register. Depends on hcc_pkg, hcc_cfg_regs and hcc_step.
//
// One input word per one-second tick on the s_ side; one result word per
// tick on the m_ side. Configuration is written through cfg_we, cfg_index
// and cfg_data, one register per cycle; the user must write it only while
// the block is idle, which the block does not enforce. A word accepted at
// an edge is in the input register after it; its result is loaded into
// the result register at the next edge at which it is free, raising m_tvalid.
// Throughput: one word per cycle while m_tready is high. The control state
// updates in the same cycle that loads the result, so the next word sees it.
// While m_tready is low the result holds and the input register still
// takes one more word; s_tready falls only when both registers are full.
// Reset clears the control state to heater off, humidifier off, no pause,
// no reading yet and a zero estimate, empties both registers and loads
// the configuration defaults.
`default_nettype none

module hysteresis_climate_controller_core
    import hcc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,   // temp_sample[10:0], hum_sample[20:11], pause_press[21]
    input  wire logic              s_tuser,   // reading_valid
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_DW-1:0]      m_tdata,   // heater_on, humidifier_on, pause_active, sensor_ok,
                                              // temp_estimate[21:4]
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    cfg_t       cfg;
    tick_t      in_reg;
    logic       in_valid_reg;
    ctl_state_t state_reg;
    ctl_state_t state_next;
    result_t    result_next;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       out_free;

    hcc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hcc_step u_step (
        .cfg        (cfg),
        .tick       (in_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.reading_valid <= s_tuser;
            in_reg.temp_sample   <= $signed(s_tdata[TEMP_W-1:0]);
            in_reg.hum_sample    <= s_tdata[TEMP_W+HUM_W-1:TEMP_W];
            in_reg.pause_press   <= s_tdata[TEMP_W+HUM_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DW-EST_W-4){1'b0}}, out_reg.temp_estimate, out_reg.sensor_ok,
                       out_reg.pause_active, out_reg.humidifier_on, out_reg.heater_on};

    a_pause_blocks_humid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.pause_active |-> !out_reg.humidifier_on)
        else $error("humidifier on while paused");

    a_ok_needs_reading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.sensor_ok |-> state_reg.have_reading)
        else $error("sensor_ok without any reading");

    a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((EST_W+1)'(out_reg.temp_estimate) >= EST_MIN)
                       && ((EST_W+1)'(out_reg.temp_estimate) <= EST_MAX))
        else $error("estimate out of range");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("control state moved without a word");

endmodule

`default_nettype wire
